// ----- rtl/swct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swct_pkg: shared types and constants of the status word change tracker
// Command codes, register indexes, stamp memory row types and field limits.
// ----------------------------------------------------------------------------
package swct_pkg;

  localparam int WORD_BITS  = 16;
  localparam int WORD_TOP   = 15;
  localparam int LANES      = 4;
  localparam int LANE_W     = 2;
  localparam int STAMP_W    = 32;
  localparam int FIELD_MAX  = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  localparam logic [STAMP_W-1:0] TIMEOUT_RST = 32'd60000;

  typedef logic [3:0]         cmd_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef stamp_t [LANES-1:0] stamp_row_t;

  typedef struct packed {
    logic       en;
    stamp_row_t data;
  } stamp_wr_t;

  localparam cmd_t CMD_POLL       = 4'd0;
  localparam cmd_t CMD_TICK       = 4'd1;
  localparam cmd_t CMD_FIELD_PEND = 4'd2;
  localparam cmd_t CMD_FIELD_READ = 4'd3;
  localparam cmd_t CMD_FIELD_POP  = 4'd4;
  localparam cmd_t CMD_WORD_PEND  = 4'd5;
  localparam cmd_t CMD_WORD_STAMP = 4'd6;
  localparam cmd_t CMD_WORD_READ  = 4'd7;
  localparam cmd_t CMD_ANY_PEND   = 4'd8;

  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_BIT_IGN  = 2'd1;
  localparam logic [1:0] REG_WORD_IGN = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/swct_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swct_in_if / swct_out_if: valid-ready channels of the change tracker
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface swct_in_if;
  import swct_pkg::*;
  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [63:0] response;
  logic [5:0]  bit_index;
  logic [5:0]  bit_count;
  logic [1:0]  word_index;

  modport source (output valid, cmd, response, bit_index, bit_count, word_index,
                  input ready);
  modport sink   (input valid, cmd, response, bit_index, bit_count, word_index,
                  output ready);
endinterface

interface swct_out_if;
  import swct_pkg::*;
  logic        valid;
  logic        ready;
  logic        changed;
  logic        flag;
  logic [31:0] value;
  logic        range_error;

  modport source (output valid, changed, flag, value, range_error, input ready);
  modport sink   (input valid, changed, flag, value, range_error, output ready);
endinterface
`default_nettype wire

// ----- rtl/swct_stamp_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swct_stamp_mem: bit time-stamp memory
// One row of four stamps per address, registered read, one write port.
// Rows never written since reset read as zero through per-row valid bits.
// ----------------------------------------------------------------------------
module swct_stamp_mem #(
  parameter int ROWS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(ROWS)-1:0]     rd_row,
  output swct_pkg::stamp_row_t        rd_data,
  input  swct_pkg::stamp_wr_t         wr,
  input  logic [$clog2(ROWS)-1:0]     wr_row
);
  import swct_pkg::*;

  stamp_row_t            mem [ROWS];
  stamp_row_t            rd_data_r;
  logic                  rd_vld_r;
  logic [ROWS-1:0]       row_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_row] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld_r[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_row];
      end
    end
  end

  // unwritten rows read as zero through their row valid bit
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

// ----- rtl/status_word_change_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// status_word_change_tracker: shadow of a polled status response
// Tracks word and bit changes with time stamps and pending flags, answers
// field, word and pending queries, and re-marks bits whose stamp expired.
// ----------------------------------------------------------------------------
// Steps: a query is latched, then executed into the output register; a
//   popcount adds a counting step, and a poll walks the stamp memory,
//   one row of four bits per cycle.
// Throughput: one transaction at a time; the next one is taken as soon as the
//   result sits in the output register, even while it waits to be taken.
// Reset: synchronous, active low; clears control, configuration and tracked state at once, no clearing pass.
// ----------------------------------------------------------------------------
module status_word_change_tracker #(
  parameter int WORDS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  swct_in_if.sink                         in_ch,
  swct_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swct_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [swct_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [swct_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import swct_pkg::*;

  localparam int NBITS  = WORD_BITS * WORDS;
  localparam int ROWS   = NBITS / LANES;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int BIT_W  = $clog2(NBITS);
  localparam int WSEL_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_WALK     = 3'd2;
  localparam logic [2:0] S_POLL_OUT = 3'd3;
  localparam logic [2:0] S_POPC     = 3'd4;

  logic [2:0]           state_r, state_nxt;

  // configuration
  stamp_t               timeout_r, timeout_nxt;
  logic [63:0]          bit_ign_r, bit_ign_nxt;
  logic [3:0]           word_ign_r, word_ign_nxt;

  // tracked state
  logic [WORD_BITS-1:0] word_val_r [WORDS];
  logic [WORD_BITS-1:0] word_val_nxt [WORDS];
  stamp_t               word_stamp_r [WORDS];
  stamp_t               word_stamp_nxt [WORDS];
  logic [WORDS-1:0]     word_pend_r, word_pend_nxt;
  logic [NBITS-1:0]     bit_val_r, bit_val_nxt;
  logic [NBITS-1:0]     bit_pend_r, bit_pend_nxt;
  stamp_t               now_ms_r, now_ms_nxt;

  // latched transaction
  cmd_t                 cmd_r, cmd_nxt;
  logic [63:0]          resp_r, resp_nxt;
  logic [5:0]           idx_r, idx_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [1:0]           widx_r, widx_nxt;

  // poll walk
  logic                 rd_busy_r, rd_busy_nxt;
  logic [ROW_W-1:0]     rd_row_r, rd_row_nxt;
  logic                 wb_vld_r, wb_vld_nxt;
  logic [ROW_W-1:0]     wb_row_r, wb_row_nxt;
  logic                 any_r, any_nxt;

  // popcount stage
  logic [31:0]          pop_src_r, pop_src_nxt;
  logic                 pop_err_r, pop_err_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_changed_r, out_changed_nxt;
  logic                 out_flag_r, out_flag_nxt;
  logic [31:0]          out_value_r, out_value_nxt;
  logic                 out_rerr_r, out_rerr_nxt;

  // stamp memory ports
  stamp_row_t           rd_data;
  stamp_wr_t            stamp_wr;

  logic                 slot_free;
  logic                 cfg_wr;
  logic [1:0]           cfg_reg;

  // ---------------------------------------------------------------------------
  // Status bit view of the stored words: bit 16w is the MSB of word w.
  // ---------------------------------------------------------------------------
  logic [NBITS-1:0]     sv;

  always_comb begin
    for (int i = 0; i < NBITS; i++) begin
      sv[i] = word_val_r[i / WORD_BITS][WORD_TOP - (i % WORD_BITS)];
    end
  end

  // ---------------------------------------------------------------------------
  // Field decode: mask over the status bits, MSB-first value, range check.
  // ---------------------------------------------------------------------------
  logic [6:0]           fsum;
  logic                 frerr;
  logic [63:0]          fmask, rmask, bv64, bp64, rv, fval_full;
  logic [31:0]          fval;
  logic                 fpend, fign;

  assign fsum  = {1'b0, idx_r} + {1'b0, cnt_r};
  assign frerr = (cnt_r > 6'(FIELD_MAX)) || (fsum > 7'(NBITS));
  assign bv64  = 64'(bit_val_r);
  assign bp64  = 64'(bit_pend_r);

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      fmask[i]      = (7'(i) >= {1'b0, idx_r}) && (7'(i) < fsum);
      rmask[63 - i] = fmask[i];
      rv[63 - i]    = bv64[i];
    end
  end

  // right-align the field so its first bit lands on top of the value
  assign fval_full = (rv & rmask) >> (7'd64 - fsum);
  assign fval      = fval_full[31:0];
  assign fpend     = |(bp64 & fmask);
  assign fign      = |(bit_ign_r & fmask);

  // ---------------------------------------------------------------------------
  // Word decode
  // ---------------------------------------------------------------------------
  logic                 w_ok;
  logic [WSEL_W-1:0]    wsel;
  logic [NBITS-1:0]     wmask;

  assign w_ok = ({1'b0, widx_r} < 3'(WORDS));
  assign wsel = widx_r[WSEL_W-1:0];

  always_comb begin
    for (int i = 0; i < NBITS; i++) begin
      wmask[i] = (2'(i / WORD_BITS) == widx_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes and configuration port
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = paddr[CFG_ADDR_W-1 -: 2];

  always_comb begin
    case (cfg_reg)
      REG_TIMEOUT:  prdata = {32'b0, timeout_r};
      REG_BIT_IGN:  prdata = bit_ign_r;
      REG_WORD_IGN: prdata = {60'b0, word_ign_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  logic [BIT_W-1:0]     bi;
  stamp_t               age;
  logic                 upd;

  always_comb begin
    state_nxt       = state_r;
    timeout_nxt     = timeout_r;
    bit_ign_nxt     = bit_ign_r;
    word_ign_nxt    = word_ign_r;
    word_val_nxt    = word_val_r;
    word_stamp_nxt  = word_stamp_r;
    word_pend_nxt   = word_pend_r;
    bit_val_nxt     = bit_val_r;
    bit_pend_nxt    = bit_pend_r;
    now_ms_nxt      = now_ms_r;
    cmd_nxt         = cmd_r;
    resp_nxt        = resp_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    widx_nxt        = widx_r;
    rd_busy_nxt     = rd_busy_r;
    rd_row_nxt      = rd_row_r;
    wb_vld_nxt      = 1'b0;
    wb_row_nxt      = wb_row_r;
    any_nxt         = any_r;
    pop_src_nxt     = pop_src_r;
    pop_err_nxt     = pop_err_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_changed_nxt = out_changed_r;
    out_flag_nxt    = out_flag_r;
    out_value_nxt   = out_value_r;
    out_rerr_nxt    = out_rerr_r;
    stamp_wr.en     = wb_vld_r;
    stamp_wr.data   = rd_data;
    bi              = '0;
    age             = '0;
    upd             = 1'b0;

    if (cfg_wr) begin
      case (cfg_reg)
        REG_TIMEOUT:  timeout_nxt  = pwdata[31:0];
        REG_BIT_IGN:  bit_ign_nxt  = pwdata;
        REG_WORD_IGN: word_ign_nxt = pwdata[3:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        // hold the transaction for the execute step
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          resp_nxt  = in_ch.response;
          idx_nxt   = in_ch.bit_index;
          cnt_nxt   = in_ch.bit_count;
          widx_nxt  = in_ch.word_index;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_r == CMD_POLL) begin
          // store changed words and stamp them, then walk the bits
          any_nxt = 1'b0;
          for (int w = 0; w < WORDS; w++) begin
            if (resp_r[63 - WORD_BITS * w -: WORD_BITS] != word_val_r[w]) begin
              any_nxt           = 1'b1;
              word_pend_nxt[w]  = 1'b1;
              word_stamp_nxt[w] = now_ms_r;
              word_val_nxt[w]   = resp_r[63 - WORD_BITS * w -: WORD_BITS];
            end
          end
          rd_busy_nxt = 1'b1;
          rd_row_nxt  = '0;
          state_nxt   = S_WALK;
        end else if (cmd_r == CMD_FIELD_POP) begin
          // pick the field now, count its ones in the next step
          pop_src_nxt = fval;
          pop_err_nxt = frerr;
          if (!frerr) begin
            bit_pend_nxt = bit_pend_r & ~fmask[NBITS-1:0];
          end
          state_nxt = S_POPC;
        end else if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_changed_nxt = 1'b0;
          out_flag_nxt    = 1'b0;
          out_value_nxt   = '0;
          out_rerr_nxt    = 1'b0;
          case (cmd_r)
            CMD_TICK: begin
              now_ms_nxt = now_ms_r + 32'd1;
            end
            CMD_FIELD_PEND: begin
              out_rerr_nxt = frerr;
              out_flag_nxt = !frerr && fpend && !fign;
            end
            CMD_FIELD_READ: begin
              out_rerr_nxt = frerr;
              if (!frerr) begin
                out_value_nxt = fval;
                bit_pend_nxt  = bit_pend_r & ~fmask[NBITS-1:0];
              end
            end
            CMD_WORD_PEND: begin
              out_flag_nxt = w_ok && word_pend_r[wsel] && !word_ign_r[widx_r];
            end
            CMD_WORD_STAMP: begin
              if (w_ok) begin
                out_value_nxt = word_stamp_r[wsel];
              end
            end
            CMD_WORD_READ: begin
              // drop the word's flag and the flags of its 16 bits
              if (w_ok) begin
                out_value_nxt       = {16'b0, word_val_r[wsel]};
                word_pend_nxt[wsel] = 1'b0;
                bit_pend_nxt        = bit_pend_r & ~wmask;
              end
            end
            CMD_ANY_PEND: begin
              out_flag_nxt = |bit_pend_r;
            end
            default: ;
          endcase
          state_nxt = S_IDLE;
        end
      end

      S_WALK: begin
        // read row k while row k-1 is written back
        if (rd_busy_r) begin
          rd_row_nxt = rd_row_r + ROW_W'(1);
          if (rd_row_r == ROW_W'(ROWS - 1)) begin
            rd_busy_nxt = 1'b0;
          end
        end
        wb_vld_nxt = rd_busy_r;
        wb_row_nxt = rd_row_r;

        if (wb_vld_r) begin
          for (int l = 0; l < LANES; l++) begin
            bi  = {wb_row_r, LANE_W'(l)};
            age = now_ms_r - rd_data[l];
            upd = (sv[bi] != bit_val_r[bi]) || (age > timeout_r);
            if (upd) begin
              any_nxt            = 1'b1;
              bit_pend_nxt[bi]   = 1'b1;
              bit_val_nxt[bi]    = sv[bi];
              stamp_wr.data[l]   = now_ms_r;
            end
          end
          if (wb_row_r == ROW_W'(ROWS - 1)) begin
            state_nxt = S_POLL_OUT;
          end
        end
      end

      S_POLL_OUT: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_changed_nxt = any_r;
          out_flag_nxt    = 1'b0;
          out_value_nxt   = '0;
          out_rerr_nxt    = 1'b0;
          state_nxt       = S_IDLE;
        end
      end

      S_POPC: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_changed_nxt = 1'b0;
          out_flag_nxt    = 1'b0;
          out_value_nxt   = pop_err_r ? 32'd0 : 32'($countones(pop_src_r));
          out_rerr_nxt    = pop_err_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= TIMEOUT_RST;
      bit_ign_r    <= '0;
      word_ign_r   <= '0;
      word_val_r   <= '{default: '0};
      word_stamp_r <= '{default: '0};
      word_pend_r  <= '0;
      bit_val_r    <= '0;
      bit_pend_r   <= '0;
      now_ms_r     <= '0;
      rd_busy_r    <= 1'b0;
      rd_row_r     <= '0;
      wb_vld_r     <= 1'b0;
      wb_row_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      timeout_r    <= timeout_nxt;
      bit_ign_r    <= bit_ign_nxt;
      word_ign_r   <= word_ign_nxt;
      word_val_r   <= word_val_nxt;
      word_stamp_r <= word_stamp_nxt;
      word_pend_r  <= word_pend_nxt;
      bit_val_r    <= bit_val_nxt;
      bit_pend_r   <= bit_pend_nxt;
      now_ms_r     <= now_ms_nxt;
      rd_busy_r    <= rd_busy_nxt;
      rd_row_r     <= rd_row_nxt;
      wb_vld_r     <= wb_vld_nxt;
      wb_row_r     <= wb_row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    resp_r        <= resp_nxt;
    idx_r         <= idx_nxt;
    cnt_r         <= cnt_nxt;
    widx_r        <= widx_nxt;
    any_r         <= any_nxt;
    pop_src_r     <= pop_src_nxt;
    pop_err_r     <= pop_err_nxt;
    out_changed_r <= out_changed_nxt;
    out_flag_r    <= out_flag_nxt;
    out_value_r   <= out_value_nxt;
    out_rerr_r    <= out_rerr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stamp memory
  // ---------------------------------------------------------------------------
  swct_stamp_mem #(
    .ROWS (ROWS)
  ) u_stamp_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_busy_r),
    .rd_row  (rd_row_r),
    .rd_data (rd_data),
    .wr      (stamp_wr),
    .wr_row  (wb_row_r)
  );

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign out_ch.valid       = out_valid_r;
  assign out_ch.changed     = out_changed_r;
  assign out_ch.flag        = out_flag_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.range_error = out_rerr_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_vld_r && rd_busy_r) |-> (rd_row_r == (wb_row_r + ROW_W'(1))))
    else $error("stamp write-back row does not trail the read row by one");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter execute");

  a_walk_clock: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |=> $stable(now_ms_r))
    else $error("millisecond counter moved during a poll walk");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POLL_OUT) |-> (!rd_busy_r && !wb_vld_r))
    else $error("poll result raised with memory accesses in flight");

  a_popc_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POPC) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_POPC))
    else $error("popcount step entered from a wrong state");

endmodule
`default_nettype wire

// ----- test/tb_status_word_change_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_status_word_change_tracker: self-checking bench for the change tracker
// Sends polls, ticks and queries through the command channel under random
// sender gaps and result-side stalls. The bench keeps its own shadow of the
// words, bits, stamps and pending flags, and checks every answer field by
// field against the answer that the shadow gives.
// ----------------------------------------------------------------------------
module tb_status_word_change_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import swct_pkg::*;

  localparam int NWORDS        = 4;
  localparam int NBITS         = NWORDS * WORD_BITS;
  localparam int DRAIN_CYCLES  = 24;      // covers a poll walk, with margin
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SEGMENT_ITEMS = 275;

  // Command codes that the block leaves unused
  localparam cmd_t CMD_UNUSED_LO = CMD_ANY_PEND + 4'd1;
  localparam cmd_t CMD_UNUSED_HI = 4'hF;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] response;
    logic [5:0]  bit_index;
    logic [5:0]  bit_count;
    logic [1:0]  word_index;
  } track_cmd_t;

  typedef struct packed {
    logic        changed;
    logic        flag;
    logic [31:0] value;
    logic        range_error;
  } track_answer_t;

  bit                    clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  swct_in_if  cmd_bus ();
  swct_out_if ans_bus ();

  status_word_change_tracker #(.WORDS(NWORDS)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_bus),
    .out_ch  (ans_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the tracker: configuration and tracked state
  logic [31:0] cfg_timeout;
  logic [63:0] cfg_bit_ign;
  logic [3:0]  cfg_word_ign;

  logic [15:0] sh_word       [NWORDS];
  logic        sh_word_pend  [NWORDS];
  logic [31:0] sh_word_stamp [NWORDS];
  logic        sh_bit        [NBITS];
  logic        sh_bit_pend   [NBITS];
  logic [31:0] sh_bit_stamp  [NBITS];
  logic [31:0] sh_now_ms;

  track_answer_t answer_q[$];        // answers owed by the block, oldest first
  logic [63:0]   last_response;      // base for small changes between polls
  int unsigned   src_gap_pct;
  int unsigned   sink_stall_pct;
  int unsigned   mismatches  = 0;
  int unsigned   cycle_count = 0;

  // Apply one accepted transaction to the shadow and return its answer.
  function automatic track_answer_t advance_shadow(track_cmd_t c);
    track_answer_t a;
    logic [15:0]   wv;
    logic          bv;
    logic [31:0]   age;
    logic          ign;
    logic          pend;
    int            lo;
    int            cnt;
    int            w;
    int            k;
    a   = '0;
    lo  = int'(c.bit_index);
    cnt = int'(c.bit_count);
    w   = int'(c.word_index);
    case (c.cmd)
      CMD_POLL: begin
        // Store changed words first; the bit pass reads the new word values
        for (k = 0; k < NWORDS; k++) begin
          wv = c.response[63 - WORD_BITS*k -: WORD_BITS];
          if (wv != sh_word[k]) begin
            a.changed        = 1'b1;
            sh_word_pend[k]  = 1'b1;
            sh_word_stamp[k] = sh_now_ms;
            sh_word[k]       = wv;
          end
        end
        for (k = 0; k < NBITS; k++) begin
          bv  = sh_word[k / WORD_BITS][WORD_TOP - k % WORD_BITS];
          age = sh_now_ms - sh_bit_stamp[k];   // wraps modulo 2^32
          if (bv != sh_bit[k] || age > cfg_timeout) begin
            a.changed       = 1'b1;
            sh_bit_pend[k]  = 1'b1;
            sh_bit_stamp[k] = sh_now_ms;
            sh_bit[k]       = bv;
          end
        end
      end
      CMD_TICK: sh_now_ms = sh_now_ms + 32'd1;
      CMD_FIELD_PEND, CMD_FIELD_READ, CMD_FIELD_POP: begin
        // A field off the end answers with an error and clears nothing
        if (cnt > FIELD_MAX || lo + cnt > NBITS) begin
          a.range_error = 1'b1;
        end else if (c.cmd == CMD_FIELD_PEND) begin
          ign  = 1'b0;
          pend = 1'b0;
          for (k = lo; k < lo + cnt; k++) begin
            ign  = ign | cfg_bit_ign[k];
            pend = pend | sh_bit_pend[k];
          end
          a.flag = pend & ~ign;
        end else begin
          for (k = lo; k < lo + cnt; k++) begin
            sh_bit_pend[k] = 1'b0;
            if (c.cmd == CMD_FIELD_READ) a.value = {a.value[30:0], sh_bit[k]};
            else a.value = a.value + 32'(sh_bit[k]);
          end
        end
      end
      CMD_WORD_PEND: a.flag = sh_word_pend[w] & ~cfg_word_ign[w];
      CMD_WORD_STAMP: a.value = sh_word_stamp[w];
      CMD_WORD_READ: begin
        sh_word_pend[w] = 1'b0;
        for (k = 0; k < WORD_BITS; k++) sh_bit_pend[w*WORD_BITS + k] = 1'b0;
        a.value = {16'd0, sh_word[w]};
      end
      CMD_ANY_PEND: begin
        // Masks do not apply here
        for (k = 0; k < NBITS; k++) a.flag = a.flag | sh_bit_pend[k];
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic track_cmd_t make_cmd(cmd_t op, logic [63:0] resp, int idx, int cnt,
                                          int w);
    track_cmd_t c;
    c.cmd        = op;
    c.response   = resp;
    c.bit_index  = 6'(idx);
    c.bit_count  = 6'(cnt);
    c.word_index = 2'(w);
    return c;
  endfunction

  // Mostly well-formed traffic: polls that move a few bits, ticks that age the stamps,
  // in-range fields, word and any-pending queries; the rest is raw fields and unused codes.
  function automatic track_cmd_t random_cmd();
    track_cmd_t  c;
    int unsigned pick;
    int unsigned cnt;
    c    = make_cmd(CMD_TICK, {$urandom, $urandom}, $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 26) begin
      c.cmd = CMD_POLL;
      case ($urandom_range(5))
        0: c.response = last_response;
        1, 2: c.response = last_response ^ (64'd1 << $urandom_range(63));
        3: c.response = last_response ^ ({48'd0, 16'($urandom)} << (16*$urandom_range(3)));
        4: c.response = $urandom_range(1) ? '1 : '0;
        default: ;
      endcase
      last_response = c.response;
    end else if (pick < 40) begin
      c.cmd = CMD_TICK;
    end else if (pick < 63) begin
      c.cmd = cmd_t'($urandom_range(CMD_FIELD_POP, CMD_FIELD_PEND));
      pick  = $urandom_range(9);
      if (pick < 7) begin
        cnt         = $urandom_range(FIELD_MAX, 1);
        c.bit_count = 6'(cnt);
        c.bit_index = 6'($urandom_range(NBITS - cnt));
      end else if (pick == 7) begin
        c.bit_count = '0;
      end
      // else keep the raw index and count; many run off the end
    end else if (pick < 82) begin
      c.cmd = cmd_t'($urandom_range(CMD_WORD_READ, CMD_WORD_PEND));
    end else if (pick < 94) begin
      c.cmd = CMD_ANY_PEND;
    end else begin
      c.cmd = cmd_t'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    end
    return c;
  endfunction

  // Present one transaction after a random gap and hold it until taken.
  // Return at the next falling edge with valid still high.
  task automatic send_cmd(input track_cmd_t c);
    while ($urandom_range(99) < src_gap_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.cmd        <= c.cmd;
    cmd_bus.response   <= c.response;
    cmd_bus.bit_index  <= c.bit_index;
    cmd_bus.bit_count  <= c.bit_count;
    cmd_bus.word_index <= c.word_index;
    do @(posedge clk); while (!cmd_bus.ready);
    answer_q.push_back(advance_shadow(c));
    @(negedge clk);
  endtask

  // Drop valid and wait until every answer is in and the block is quiet.
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Read a register over APB and compare with the shadow configuration.
  task automatic check_reg(input logic [1:0] idx);
    logic [63:0] want;
    case (idx)
      REG_TIMEOUT:  want = {32'd0, cfg_timeout};
      REG_BIT_IGN:  want = cfg_bit_ign;
      default:      want = {60'd0, cfg_word_ign};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      mismatches++;
      $display("%0t: register %0d read expected %0h actual %0h", $realtime, idx, want,
               prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write a register, mirror it into the shadow, then read it back.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TIMEOUT:  cfg_timeout  = data[31:0];
      REG_BIT_IGN:  cfg_bit_ign  = data;
      REG_WORD_IGN: cfg_word_ign = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    check_reg(idx);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  // Check each answer against the oldest one owed
  always @(posedge clk) begin
    track_answer_t want;
    if (rst_n && ans_bus.valid && ans_bus.ready) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        $display("%0t: answer with none owed: changed %0b flag %0b value %0h error %0b",
                 $realtime, ans_bus.changed, ans_bus.flag, ans_bus.value,
                 ans_bus.range_error);
      end else begin
        want = answer_q.pop_front();
        compare_field("changed", 32'(want.changed), 32'(ans_bus.changed));
        compare_field("flag", 32'(want.flag), 32'(ans_bus.flag));
        compare_field("value", want.value, ans_bus.value);
        compare_field("range_error", 32'(want.range_error), 32'(ans_bus.range_error));
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) ans_bus.ready <= ($urandom_range(99) >= sink_stall_pct);

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL status_word_change_tracker");
      $finish;
    end
  end

  // Check reset values, then drive every register to all ones and back to its reset value.
  task automatic test_register_access();
    check_reg(REG_TIMEOUT);
    check_reg(REG_BIT_IGN);
    check_reg(REG_WORD_IGN);
    write_reg(REG_TIMEOUT, 64'(32'hFFFF_FFFF));
    write_reg(REG_BIT_IGN, '1);
    write_reg(REG_WORD_IGN, 64'hF);
    write_reg(REG_TIMEOUT, 64'(TIMEOUT_RST));
    write_reg(REG_BIT_IGN, '0);
    write_reg(REG_WORD_IGN, '0);
  endtask

  // Every command at least once, field extremes, empty and off-the-end fields.
  task automatic test_basic_commands();
    send_cmd(make_cmd(CMD_ANY_PEND, '0, 0, 0, 0));
    send_cmd(make_cmd(CMD_POLL, '1, 0, 0, 0));
    send_cmd(make_cmd(CMD_ANY_PEND, '0, 0, 0, 0));
    send_cmd(make_cmd(CMD_FIELD_PEND, '0, 0, 32, 0));
    send_cmd(make_cmd(CMD_FIELD_READ, '0, 32, 32, 0));   // ends exactly at the last bit
    send_cmd(make_cmd(CMD_FIELD_POP, '0, 63, 1, 0));
    send_cmd(make_cmd(CMD_FIELD_READ, '0, 63, 2, 0));    // one bit past the end
    send_cmd(make_cmd(CMD_FIELD_POP, '0, 0, 63, 0));     // count above the field limit
    send_cmd(make_cmd(CMD_FIELD_PEND, '0, 5, 0, 0));     // empty field
    send_cmd(make_cmd(CMD_WORD_READ, '0, 0, 0, 3));
    send_cmd(make_cmd(CMD_TICK, '0, 0, 0, 0));
    send_cmd(make_cmd(CMD_POLL, 64'h8000_0001_A5A5_5A5A, 0, 0, 0));
    send_cmd(make_cmd(CMD_WORD_STAMP, '0, 0, 0, 0));
    send_cmd(make_cmd(CMD_WORD_PEND, '0, 0, 0, 1));
    send_cmd(make_cmd(CMD_FIELD_READ, '0, 16, 16, 0));
    send_cmd(make_cmd(CMD_UNUSED_LO, '1, 63, 63, 3));
    send_cmd(make_cmd(CMD_UNUSED_HI, '0, 0, 1, 0));
  endtask

  // Re-mark bits by age: zero timeout expires anything older than now,
  // the largest timeout never expires.
  task automatic test_bit_expiry();
    settle();
    write_reg(REG_TIMEOUT, '0);
    send_cmd(make_cmd(CMD_POLL, 64'h8000_0001_A5A5_5A5A, 0, 0, 0));
    send_cmd(make_cmd(CMD_POLL, 64'h8000_0001_A5A5_5A5A, 0, 0, 0));
    send_cmd(make_cmd(CMD_TICK, '0, 0, 0, 0));
    send_cmd(make_cmd(CMD_POLL, 64'h8000_0001_A5A5_5A5A, 0, 0, 0));
    settle();
    write_reg(REG_TIMEOUT, 64'(32'hFFFF_FFFF));
    send_cmd(make_cmd(CMD_TICK, '0, 0, 0, 0));
    send_cmd(make_cmd(CMD_POLL, 64'h8000_0001_A5A5_5A5A, 0, 0, 0));
  endtask

  // Masked bits and words hide pending updates; any-pending ignores masks.
  task automatic test_ignore_masks();
    settle();
    write_reg(REG_BIT_IGN, '1);
    write_reg(REG_WORD_IGN, 64'hF);
    send_cmd(make_cmd(CMD_POLL, ~64'h8000_0001_A5A5_5A5A, 0, 0, 0));
    send_cmd(make_cmd(CMD_FIELD_PEND, '0, 0, 32, 0));
    send_cmd(make_cmd(CMD_WORD_PEND, '0, 0, 0, 2));
    send_cmd(make_cmd(CMD_ANY_PEND, '0, 0, 0, 0));
    settle();
    write_reg(REG_BIT_IGN, 64'h1);
    write_reg(REG_WORD_IGN, 64'h5);
    send_cmd(make_cmd(CMD_FIELD_PEND, '0, 0, 1, 0));
    send_cmd(make_cmd(CMD_FIELD_PEND, '0, 1, 4, 0));
    send_cmd(make_cmd(CMD_WORD_PEND, '0, 0, 0, 1));
  endtask

  // Three phases of sender gaps and result stalls, each split into segments with fresh settings.
  task automatic test_random_traffic();
    int phase;
    int seg;
    int n;
    for (phase = 0; phase < 3; phase++) begin
      src_gap_pct    = (phase == 0) ? 22 : (phase == 1) ? 76 : 0;
      sink_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 22 : 0;
      for (seg = 0; seg < 2; seg++) begin
        settle();
        // Small timeouts let a few ticks expire bits; hit both extremes too
        case ($urandom_range(3))
          0:       write_reg(REG_TIMEOUT, '0);
          1:       write_reg(REG_TIMEOUT, 64'(32'hFFFF_FFFF));
          default: write_reg(REG_TIMEOUT, 64'($urandom_range(12, 1)));
        endcase
        write_reg(REG_BIT_IGN, $urandom_range(1) ?
                  ({$urandom, $urandom} & {$urandom, $urandom}) : 64'd0);
        write_reg(REG_WORD_IGN, 64'($urandom_range(15)));
        for (n = 0; n < SEGMENT_ITEMS; n++) send_cmd(random_cmd());
      end
    end
  endtask

  initial begin
    int k;
    // Hold every input at a known value from time zero
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.cmd        = CMD_POLL;
    cmd_bus.response   = '0;
    cmd_bus.bit_index  = '0;
    cmd_bus.bit_count  = '0;
    cmd_bus.word_index = '0;
    ans_bus.ready      = 1'b0;
    src_gap_pct        = 22;
    sink_stall_pct     = 76;
    last_response      = '0;

    // Shadow starts from the reset state
    cfg_timeout  = TIMEOUT_RST;
    cfg_bit_ign  = '0;
    cfg_word_ign = '0;
    sh_now_ms    = '0;
    for (k = 0; k < NWORDS; k++) begin
      sh_word[k]       = '0;
      sh_word_pend[k]  = 1'b0;
      sh_word_stamp[k] = '0;
    end
    for (k = 0; k < NBITS; k++) begin
      sh_bit[k]       = 1'b0;
      sh_bit_pend[k]  = 1'b0;
      sh_bit_stamp[k] = '0;
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_basic_commands();
    test_bit_expiry();
    test_ignore_masks();
    test_random_traffic();
    settle();

    if (mismatches == 0) begin
      $display("PASS status_word_change_tracker");
    end else begin
      $display("FAIL status_word_change_tracker");
    end
    $finish;
  end

endmodule
`default_nettype wire
